/* sv/spd_pkg.sv */
package spd_pkg;
    localparam int MaxFramesDefault = 16;
    localparam int StoreDepth = 16;
    localparam logic [7:0] SyncByte = 8'hAA;
    localparam logic [6:0] CkInit = 7'h7F;
    localparam logic [15:0] TimeoutReset = 16'd20000;
    localparam logic [15:0] CommandReset = 16'h0100;
    localparam logic [3:0] ProtocolReset = 4'd1;

    localparam logic [1:0] CfgTimeout = 2'd0;
    localparam logic [1:0] CfgCommand = 2'd1;
    localparam logic [1:0] CfgProtocol = 2'd2;

    localparam logic [2:0] KindPayload = 3'd0;
    localparam logic [2:0] KindEmpty = 3'd1;
    localparam logic [2:0] KindChecksum = 3'd2;
    localparam logic [2:0] KindHighBit = 3'd3;
    localparam logic [2:0] KindTimeout = 3'd4;
    localparam logic [2:0] KindTooMany = 3'd5;

    localparam logic OpByte = 1'b0;
    localparam logic OpTick = 1'b1;
endpackage

/* sv/septet_packet_deframer.sv */
// Channel  Direction  Handshake        Payload
// cfg      in         valid/ready      index(2), data(16)
// in       in         valid/stall      opcode, rx_byte
// out      out        valid/stall      kind, addresses, command, frame_index, payload, last
// Each item is accepted, then processed; o_stall stays high until the block is idle again.
// A finished packet whose command matches the filter emits its frames one per cycle from
// the payload RAM, reading one entry ahead; output stall holds the sequencer. Reset is
// synchronous and clears all control state; the payload RAM is not cleared.
module septet_packet_deframer #(
    parameter int MAX_FRAMES = spd_pkg::MaxFramesDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_opcode,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_kind,
    output logic [15:0] o_dest_address,
    output logic [15:0] o_source_address,
    output logic [15:0] o_command_word,
    output logic [3:0]  o_frame_index,
    output logic [31:0] o_payload,
    output logic        o_last
);
    import spd_pkg::*;

    localparam int Limit = (MAX_FRAMES < StoreDepth) ? MAX_FRAMES : StoreDepth;
    localparam logic [7:0] LimitB = 8'(Limit);

    typedef enum logic [2:0] {S_IDLE, S_PROC, S_READ, S_EMIT, S_ERR} t_state;
    typedef enum logic [1:0] {P_HUNT, P_HEADER, P_FRAMES} t_phase;

    t_state r_state;
    t_phase r_phase;
    logic [15:0] r_timeout, r_cmd_filter;
    logic [3:0]  r_proto;
    logic        r_op;
    logic [7:0]  r_b;
    logic [3:0]  r_pos;
    logic [63:0] r_hdr;
    logic [6:0]  r_ck;
    logic [31:0] r_frame;
    logic [15:0] r_idle;
    logic [4:0]  r_emit;
    logic [4:0]  r_rd;
    logic [2:0]  r_err;

    logic        ram_we;
    logic [3:0]  ram_raddr;
    logic [31:0] ram_rdata;
    logic [6:0]  ck_next;
    logic [7:0]  count;

    assign o_cfg_ready = 1'b1;
    assign o_stall = (r_state != S_IDLE);
    assign ck_next = r_ck - r_b[6:0];
    assign count = r_hdr[63:56];
    assign ram_we = (r_state == S_PROC) && (r_op == OpByte) && (r_phase == P_FRAMES)
                    && !r_b[7] && (r_pos == 4'd5) && (ck_next == 7'd0);
    // hold the read address while a result waits so the entry ahead stays put
    assign ram_raddr = (o_valid && i_stall) ? 4'(r_rd - 5'd1) : r_rd[3:0];

    spd_ram #(.Width(32), .Depth(StoreDepth)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(r_emit[3:0]), .i_wdata(r_frame),
        .i_raddr(ram_raddr), .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= P_HUNT;
            r_timeout <= TimeoutReset;
            r_cmd_filter <= CommandReset;
            r_proto <= ProtocolReset;
            r_pos <= '0;
            r_hdr <= '0;
            r_ck <= CkInit;
            r_frame <= '0;
            r_idle <= '0;
            r_emit <= '0;
            r_rd <= '0;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CfgTimeout:  r_timeout <= i_cfg_data;
                    CfgCommand:  r_cmd_filter <= i_cfg_data;
                    CfgProtocol: r_proto <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op <= i_opcode;
                        r_b <= i_rx_byte;
                        r_state <= S_PROC;
                    end
                end
                S_PROC: begin
                    r_state <= S_IDLE;
                    if (r_op == OpTick) begin
                        if (r_idle >= r_timeout) begin
                            r_idle <= '0;
                            r_phase <= P_HUNT;
                            r_err <= KindTimeout;
                            r_state <= S_ERR;
                        end else begin
                            r_idle <= r_idle + 16'd1;
                        end
                    end else if (r_phase == P_HUNT) begin
                        if (r_b == SyncByte) begin
                            r_phase <= P_HEADER;
                            r_pos <= '0;
                            r_hdr <= '0;
                            r_ck <= CkInit;
                        end
                    end else if (r_b[7]) begin
                        r_phase <= P_HUNT;
                        r_err <= KindHighBit;
                        r_state <= S_ERR;
                    end else begin
                        r_ck <= ck_next;
                        if (r_phase == P_HEADER) begin
                            if (r_pos < 4'd8) begin
                                r_hdr[r_pos[2:0]*8 +: 8] <= r_b;
                            end
                            r_pos <= r_pos + 4'd1;
                            if (r_pos == 4'd8) begin
                                r_phase <= P_HUNT;
                                if (r_hdr[39:36] != r_proto) begin
                                end else if (ck_next != 7'd0) begin
                                    r_err <= KindChecksum;
                                    r_state <= S_ERR;
                                end else if (count > LimitB) begin
                                    r_err <= KindTooMany;
                                    r_state <= S_ERR;
                                end else if (count == 8'd0) begin
                                    r_idle <= '0;
                                    r_emit <= '0;
                                    r_rd <= '0;
                                    if (r_hdr[55:40] == r_cmd_filter) begin
                                        r_state <= S_READ;
                                    end
                                end else begin
                                    r_phase <= P_FRAMES;
                                    r_pos <= '0;
                                    r_emit <= '0;
                                    r_frame <= '0;
                                    r_ck <= CkInit;
                                end
                            end
                        end else begin
                            if (r_pos < 4'd4) begin
                                r_frame[r_pos[1:0]*8 +: 8] <= r_b;
                                r_pos <= r_pos + 4'd1;
                            end else if (r_pos == 4'd4) begin
                                for (int i = 0; i < 4; i++) begin
                                    if (r_b[i]) r_frame[i*8+7] <= 1'b1;
                                end
                                r_pos <= r_pos + 4'd1;
                            end else if (ck_next != 7'd0) begin
                                r_phase <= P_HUNT;
                                r_err <= KindChecksum;
                                r_state <= S_ERR;
                            end else begin
                                r_emit <= r_emit + 5'd1;
                                r_pos <= '0;
                                r_frame <= '0;
                                r_ck <= CkInit;
                                if ({3'd0, r_emit + 5'd1} >= count) begin
                                    r_phase <= P_HUNT;
                                    r_idle <= '0;
                                    r_rd <= '0;
                                    if (r_hdr[55:40] == r_cmd_filter) begin
                                        r_state <= S_READ;
                                    end
                                end
                            end
                        end
                    end
                end
                S_READ: begin
                    r_rd <= r_rd + 5'd1;
                    r_state <= S_EMIT;
                    o_valid <= 1'b0;
                end
                S_EMIT: begin
                    if (!o_valid || !i_stall) begin
                        if (o_valid && o_last) begin
                            o_valid <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            o_valid <= 1'b1;
                            o_dest_address <= r_hdr[15:0];
                            o_source_address <= r_hdr[31:16];
                            o_command_word <= r_hdr[55:40];
                            if (count == 8'd0) begin
                                o_kind <= KindEmpty;
                                o_frame_index <= '0;
                                o_payload <= '0;
                                o_last <= 1'b1;
                            end else begin
                                o_kind <= KindPayload;
                                o_frame_index <= 4'(r_rd - 5'd1);
                                o_payload <= ram_rdata;
                                o_last <= ({3'd0, r_rd} >= count);
                                r_rd <= r_rd + 5'd1;
                            end
                        end
                    end
                end
                S_ERR: begin
                    if (!o_valid) begin
                        o_valid <= 1'b1;
                        o_kind <= r_err;
                        o_dest_address <= '0;
                        o_source_address <= '0;
                        o_command_word <= '0;
                        o_frame_index <= '0;
                        o_payload <= '0;
                        o_last <= 1'b1;
                    end else if (!i_stall) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("accepting while busy");
    a_valid_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_EMIT || r_state == S_ERR)) else $error("stray valid");
    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_rd <= 5'(StoreDepth + 1))) else $error("read overrun");
endmodule

/* sv/spd_ram.sv */
module spd_ram #(
    parameter int Width = 32,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* bench/tb_septet_packet_deframer.sv */
`timescale 1ns / 1ps

module tb_septet_packet_deframer;
    import spd_pkg::*;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] dest;
        logic [15:0] src;
        logic [15:0] cmd;
        logic [3:0]  idx;
        logic [31:0] pay;
        logic        last;
    } t_frame_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_opcode = OpByte;
    logic [7:0]  i_rx_byte = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_kind;
    logic [15:0] o_dest_address;
    logic [15:0] o_source_address;
    logic [15:0] o_command_word;
    logic [3:0]  o_frame_index;
    logic [31:0] o_payload;
    logic        o_last;

    septet_packet_deframer dut (.*);

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // predictor state
    logic [15:0] m_timeout;
    logic [15:0] m_filter;
    logic [3:0]  m_proto;
    logic [1:0]  m_phase;
    logic [6:0]  m_pos;
    logic [63:0] m_hdr;
    logic [6:0]  m_ck;
    logic [31:0] m_frame;
    logic [31:0] m_store [StoreDepth];
    logic [15:0] m_idle;
    logic [4:0]  m_count;
    // protocol nibble placed in sent headers
    logic [3:0]  tx_proto;

    localparam logic [1:0] PhHunt = 2'd0;
    localparam logic [1:0] PhHeader = 2'd1;
    localparam logic [1:0] PhFrames = 2'd2;

    t_frame_result expected_q[$];
    int errors = 0;
    int results_seen = 0;
    int items_sent = 0;
    int stall_pct = 38;
    int idle_cycles = 0;
    int kind_seen [6];

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function automatic logic [7:0] hb(input int i);
        return m_hdr[i*8 +: 8];
    endfunction

    function automatic t_frame_result mk(input logic [2:0] k, input logic hdr,
                                         input logic [3:0] idx, input logic [31:0] pay);
        t_frame_result r;
        r.kind = k;
        r.dest = hdr ? {hb(1), hb(0)} : 16'h0;
        r.src  = hdr ? {hb(3), hb(2)} : 16'h0;
        r.cmd  = hdr ? {hb(6), hb(5)} : 16'h0;
        r.idx  = idx;
        r.pay  = pay;
        r.last = 1'b0;
        return r;
    endfunction

    task automatic finish_packet(inout t_frame_result rs[$]);
        m_idle = '0;
        m_phase = PhHunt;
        if ({hb(6), hb(5)} == m_filter) begin
            if (hb(7) == 8'd0) rs.push_back(mk(KindEmpty, 1'b1, 4'd0, 32'd0));
            else for (int i = 0; i < hb(7) && i < StoreDepth; i++)
                rs.push_back(mk(KindPayload, 1'b1, i[3:0], m_store[i]));
        end
    endtask

    task automatic predict_item(input logic op, input logic [7:0] b);
        t_frame_result rs[$];
        int lim;
        lim = MaxFramesDefault < StoreDepth ? MaxFramesDefault : StoreDepth;
        if (op == OpTick) begin
            if (m_idle >= m_timeout) begin
                m_idle = '0;
                m_phase = PhHunt;
                rs.push_back(mk(KindTimeout, 1'b0, 4'd0, 32'd0));
            end else m_idle++;
        end else if (m_phase == PhHunt) begin
            if (b == SyncByte) begin
                m_phase = PhHeader; m_pos = '0; m_hdr = '0; m_ck = CkInit;
            end
        end else if (b[7]) begin
            m_phase = PhHunt;
            rs.push_back(mk(KindHighBit, 1'b0, 4'd0, 32'd0));
        end else begin
            m_ck = m_ck - b[6:0];
            if (m_phase == PhHeader) begin
                if (m_pos < 7'd8) m_hdr[m_pos*8 +: 8] = b;
                m_pos++;
                if (m_pos >= 7'd9) begin
                    if (m_hdr[39:36] != m_proto) m_phase = PhHunt;
                    else if (m_ck != 7'd0) begin
                        m_phase = PhHunt;
                        rs.push_back(mk(KindChecksum, 1'b0, 4'd0, 32'd0));
                    end else if (hb(7) > lim) begin
                        m_phase = PhHunt;
                        rs.push_back(mk(KindTooMany, 1'b0, 4'd0, 32'd0));
                    end else if (hb(7) == 8'd0) finish_packet(rs);
                    else begin
                        m_phase = PhFrames; m_pos = '0; m_count = '0;
                        m_frame = '0; m_ck = CkInit;
                    end
                end
            end else if (m_pos < 7'd4) begin
                m_frame[m_pos*8 +: 8] = b; m_pos++;
            end else if (m_pos == 7'd4) begin
                for (int i = 0; i < 4; i++) if (b[i]) m_frame[i*8+7] = 1'b1;
                m_pos++;
            end else if (m_ck != 7'd0) begin
                m_phase = PhHunt;
                rs.push_back(mk(KindChecksum, 1'b0, 4'd0, 32'd0));
            end else begin
                m_store[m_count[3:0]] = m_frame;
                m_count++;
                m_pos = '0; m_frame = '0; m_ck = CkInit;
                if ({3'd0, m_count} >= hb(7)) finish_packet(rs);
            end
        end
        if (rs.size() > 0) rs[rs.size()-1].last = 1'b1;
        foreach (rs[i]) expected_q.push_back(rs[i]);
    endtask

    task automatic send_item(input logic op, input logic [7:0] b);
        @(negedge i_clk);
        while (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
            i_valid <= 1'b0;
            i_rx_byte <= 8'($urandom);
            @(negedge i_clk);
        end
        i_valid <= 1'b1; i_opcode <= op; i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_item(op, b);
        items_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_q.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        drain();
        i_cfg_valid <= 1'b1; i_cfg_index <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CfgTimeout:  m_timeout = val;
            CfgCommand:  m_filter = val;
            CfgProtocol: begin
                m_proto = val[3:0];
                tx_proto = val[3:0];
            end
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // sends one packet; corrupt: 0 good, 1 bad header ck, 2 bad frame ck, 3 high bit
    task automatic send_packet(input logic [15:0] cmd, input logic [7:0] count,
                               input int corrupt);
        logic [7:0] h[9];
        logic [7:0] f[6];
        logic [6:0] ck;
        h[0] = 8'($urandom_range(127)); h[1] = 8'($urandom_range(127));
        h[2] = 8'($urandom_range(127)); h[3] = 8'($urandom_range(127));
        h[4] = {tx_proto, 4'($urandom)}; h[4][7] = 1'b0;
        h[5] = {1'b0, cmd[6:0]}; h[6] = {1'b0, cmd[14:8]};
        h[7] = count;
        ck = CkInit;
        for (int i = 0; i < 8; i++) ck = ck - h[i][6:0];
        h[8] = {1'b0, ck};
        if (corrupt == 1) h[8] = h[8] ^ 8'h01;
        send_item(OpByte, SyncByte);
        for (int i = 0; i < 9; i++) send_item(OpByte, h[i]);
        for (int fr = 0; fr < count && count <= StoreDepth; fr++) begin
            ck = CkInit;
            for (int i = 0; i < 5; i++) begin
                f[i] = 8'($urandom_range(127));
                if (i == 4) f[i][7:4] = 4'h0;
                ck = ck - f[i][6:0];
            end
            f[5] = {1'b0, ck};
            if (corrupt == 2 && fr == count - 1) f[5] = f[5] ^ 8'h10;
            if (corrupt == 3 && fr == count - 1) f[2] = f[2] | 8'h80;
            for (int i = 0; i < 6; i++) send_item(OpByte, f[i]);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles > 20000) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    always @(posedge i_clk) begin
        t_frame_result got, exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_kind, o_dest_address, o_source_address, o_command_word,
                    o_frame_index, o_payload, o_last};
            results_seen++;
            if (expected_q.size() == 0) report("result with none expected");
            else begin
                exp_r = expected_q.pop_front();
                if (exp_r.kind <= KindTooMany) kind_seen[exp_r.kind]++;
                if (got.kind != exp_r.kind)
                    report($sformatf("kind %0d exp %0d", got.kind, exp_r.kind));
                if (got.dest != exp_r.dest)
                    report($sformatf("dest %h exp %h", got.dest, exp_r.dest));
                if (got.src != exp_r.src)
                    report($sformatf("src %h exp %h", got.src, exp_r.src));
                if (got.cmd != exp_r.cmd)
                    report($sformatf("cmd %h exp %h", got.cmd, exp_r.cmd));
                if (got.idx != exp_r.idx)
                    report($sformatf("idx %h exp %h", got.idx, exp_r.idx));
                if (got.pay != exp_r.pay)
                    report($sformatf("pay %h exp %h", got.pay, exp_r.pay));
                if (got.last != exp_r.last)
                    report($sformatf("last %b exp %b", got.last, exp_r.last));
            end
        end
    end

    always @(negedge i_clk) begin
        i_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    task automatic test_directed();
        send_item(OpByte, 8'h00);
        send_item(OpByte, 8'hFF);
        send_packet(CommandReset, 8'd0, 0);
        send_packet(CommandReset, 8'd1, 0);
        send_packet(CommandReset, 8'd16, 0);
        send_packet(CommandReset, 8'd17, 0);
        send_packet(CommandReset, 8'd255, 0);
        send_packet(CommandReset, 8'd2, 1);
        send_packet(CommandReset, 8'd2, 2);
        send_packet(CommandReset, 8'd1, 3);
        send_packet(16'h0203, 8'd1, 0);
        send_item(OpByte, SyncByte);
        send_item(OpByte, SyncByte);
        send_item(OpTick, 8'h00);
    endtask

    task automatic test_protocol();
        write_reg(CfgProtocol, 16'd15);
        send_packet(CommandReset, 8'd1, 0);
        write_reg(CfgProtocol, 16'd0);
        send_packet(CommandReset, 8'd1, 0);
        tx_proto = 4'd3;
        send_packet(CommandReset, 8'd1, 0);
        tx_proto = 4'd0;
        write_reg(CfgProtocol, 16'(ProtocolReset));
    endtask

    task automatic test_timeout();
        write_reg(CfgTimeout, 16'd0);
        send_item(OpTick, 8'h00);
        send_item(OpByte, SyncByte);
        send_item(OpTick, 8'h00);
        write_reg(CfgTimeout, 16'd3);
        for (int i = 0; i < 10; i++) send_item(OpTick, 8'($urandom));
        write_reg(CfgTimeout, 16'hFFFF);
        send_item(OpTick, 8'h00);
    endtask

    task automatic test_random(input int n_items);
        int start;
        logic [15:0] cmd;
        start = items_sent;
        while (items_sent - start < n_items) begin
            case ($urandom_range(9))
                0: send_item(OpByte, 8'($urandom));
                1: send_item(OpTick, 8'($urandom));
                2: send_packet(CommandReset, 8'($urandom_range(20)), $urandom_range(3));
                default: begin
                    cmd = ($urandom_range(4) == 0) ? 16'($urandom) & 16'h7F7F : m_filter;
                    send_packet(cmd, ($urandom_range(4) == 0) ? 8'($urandom_range(16))
                                : 8'($urandom_range(3)), ($urandom_range(5) < 4) ? 0 :
                                $urandom_range(3));
                end
            endcase
        end
    endtask

    initial begin
        m_timeout = TimeoutReset; m_filter = CommandReset; m_proto = ProtocolReset;
        tx_proto = ProtocolReset;
        m_phase = PhHunt; m_pos = '0; m_hdr = '0; m_ck = CkInit; m_frame = '0;
        m_idle = '0; m_count = '0;
        foreach (m_store[i]) m_store[i] = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_protocol();
        test_timeout();
        write_reg(CfgCommand, 16'h7F7F);
        write_reg(CfgTimeout, 16'd40);
        stall_pct = 0;
        test_random(40);
        stall_pct = 38;
        write_reg(CfgCommand, 16'h0000);
        test_random(30);
        write_reg(CfgCommand, CommandReset);
        write_reg(CfgTimeout, 16'd1);
        test_random(30);
        drain();
        $display("sent %0d items, checked %0d results", items_sent, results_seen);
        $display("kinds payload/empty/ck/high/timeout/toomany: %0d %0d %0d %0d %0d %0d",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3],
                 kind_seen[4], kind_seen[5]);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
